[sv/nsr_pkg.sv]
// ----------------------------------------------------------------------------
// nsr_pkg: shared types and constants of the n-sigma row selector
// Column count, row limit, pass codes and the status codes of a result.
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int COLUMNS    = 4;
    localparam int MAX_ROWS   = 1048576;
    localparam int ROW_W      = 20;
    localparam int CNT_W      = 21;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 37;
    localparam int DEV_W      = 55;
    localparam int SIGMA_W    = 28;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int BOUND_W    = SIGMA_W + CFG_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [DEV_W-1:0]           dev_t;
    typedef logic [SIGMA_W-1:0]         sigma_t;

    typedef enum logic [1:0] {
        PASS_MEAN     = 2'd0,
        PASS_DEV      = 2'd1,
        PASS_CLASSIFY = 2'd2,
        PASS_BAD      = 2'd3
    } pass_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ORDER = 2'd1,
        ST_SAT   = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_NSIGMA  = 2'd0,
        CFG_EXCLUDE = 2'd1,
        CFG_ENABLE  = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_LOAD,
        FS_DIV,
        FS_SQRT,
        FS_NEXT
    } fin_state_t;

    typedef struct packed {
        logic in_bound;
        logic enabled;
    } lane_cut_t;

endpackage

[sv/nsr_if.sv]
// ----------------------------------------------------------------------------
// nsr_in_if / nsr_out_if: valid-ready channels of the selector
// Input carries one row; output carries one result.
// ----------------------------------------------------------------------------
interface nsr_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [15:0]       sample_a;
    logic signed [15:0]       sample_b;
    logic signed [15:0]       sample_c;
    logic signed [15:0]       sample_d;
    logic                     last_in_pass;
    modport source (output valid, req_type, sample_a, sample_b, sample_c, sample_d,
                    last_in_pass, input ready);
    modport sink (input valid, req_type, sample_a, sample_b, sample_c, sample_d,
                  last_in_pass, output ready);
endinterface

interface nsr_out_if;
    logic        valid;
    logic        ready;
    logic        keep_row;
    logic [19:0] row_number;
    logic [1:0]  status;
    logic        pass_done;
    modport source (output valid, keep_row, row_number, status, pass_done, input ready);
    modport sink (input valid, keep_row, row_number, status, pass_done, output ready);
endinterface

[sv/nsr_lane.sv]
// ----------------------------------------------------------------------------
// nsr_lane: one column's accumulators and cut test
// Holds sum, deviation sum, mean and sigma; accumulates per row.
// ----------------------------------------------------------------------------
module nsr_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [15:0]  sample,
    input  logic                acc_sum,
    input  logic                acc_dev,
    input  logic                clr_sum,
    input  logic                clr_dev,
    input  logic                set_mean,
    input  logic signed [15:0]  mean_val,
    input  logic                set_sigma,
    input  logic [nsr_pkg::SIGMA_W-1:0] sigma_val,
    input  logic [15:0]         nsigma,
    input  logic                enabled,
    output logic signed [36:0]  sum,
    output logic [54:0]         dev,
    output nsr_pkg::lane_cut_t  cut
);
    import nsr_pkg::*;

    sum_t            sum_reg;
    dev_t            dev_reg;
    sample_t         mean_reg;
    sigma_t          sigma_reg;
    logic signed [16:0] diff;
    logic [16:0]     ad;
    logic [33:0]     sq;
    logic [BOUND_W-1:0] bound;

    assign diff  = 17'(sample) - 17'(mean_reg);
    assign ad    = diff[16] ? 17'(-diff) : diff;
    assign sq    = 34'(ad) * 34'(ad);
    assign bound = BOUND_W'(nsigma) * BOUND_W'(sigma_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            dev_reg   <= '0;
            mean_reg  <= '0;
            sigma_reg <= '0;
        end
        else
        begin
            if (clr_sum)
                sum_reg <= '0;
            else if (acc_sum)
                sum_reg <= sum_reg + SUM_W'(sample);
            if (clr_dev)
                dev_reg <= '0;
            else if (acc_dev)
                dev_reg <= dev_reg + DEV_W'(sq);
            if (set_mean)
                mean_reg <= mean_val;
            if (set_sigma)
                sigma_reg <= sigma_val;
        end
    end

    assign sum          = sum_reg;
    assign dev          = dev_reg;
    assign cut.in_bound = BOUND_W'({ad, 8'd0}) <= bound;
    assign cut.enabled  = enabled;
endmodule

[sv/nsr_finish.sv]
// ----------------------------------------------------------------------------
// nsr_finish: shared pass-end unit
// Restoring divider and bit-pair square root, one bit per cycle, lanes in turn.
// ----------------------------------------------------------------------------
module nsr_finish (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                is_sqrt,
    input  logic [20:0]         count,
    input  logic [4*37-1:0]     sums,
    input  logic [4*55-1:0]     devs,
    output logic                busy,
    output logic [3:0]          mean_we,
    output logic [15:0]         mean_val,
    output logic [3:0]          sigma_we,
    output logic [nsr_pkg::SIGMA_W-1:0] sigma_val
);
    import nsr_pkg::*;

    fin_state_t      state_reg, state_next;
    logic            sqrt_reg;
    logic [1:0]      lane_reg;
    logic [5:0]      bit_reg;
    logic [54:0]     num_reg;     // dividend magnitude, shifted out
    logic [54:0]     quo_reg;
    logic [55:0]     rem_reg;
    logic [20:0]     div_reg;
    logic            neg_reg;
    logic [55:0]     rad_reg;     // quotient with a zero on top, two bits per step
    logic [27:0]     root_reg;
    logic [56:0]     srem_reg;
    logic [36:0]     cur_sum;
    logic [36:0]     mag;
    logic [55:0]     rem_sh;
    logic [56:0]     srem_sh;
    logic [56:0]     trial;
    logic            rem_nz;
    logic [54:0]     qfin;
    logic signed [37:0] mean_full;

    assign cur_sum = sums[lane_reg*37 +: 37];
    assign mag     = cur_sum[36] ? 37'(-cur_sum) : cur_sum;
    assign rem_sh  = {rem_reg[54:0], num_reg[54]};
    assign srem_sh = {srem_reg[54:0], rad_reg[55:54]};
    assign trial   = 57'({root_reg, 2'b01});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE: if (start) state_next = FS_LOAD;
            FS_LOAD: state_next = FS_DIV;
            FS_DIV:  if (bit_reg == '0) state_next = sqrt_reg ? FS_SQRT : FS_NEXT;
            FS_SQRT: if (bit_reg == '0) state_next = FS_NEXT;
            FS_NEXT: state_next = (lane_reg == 2'd3) ? FS_IDLE : FS_LOAD;
            default: state_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            lane_reg  <= '0;
            sqrt_reg  <= 1'b0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                FS_IDLE:
                begin
                    if (start)
                    begin
                        sqrt_reg <= is_sqrt;
                        lane_reg <= '0;
                    end
                end
                FS_LOAD:
                begin
                    bit_reg <= 6'd54;
                end
                FS_DIV:
                begin
                    if (bit_reg == '0)
                        bit_reg <= 6'd27;
                    else
                        bit_reg <= bit_reg - 6'd1;
                end
                FS_SQRT:
                begin
                    if (bit_reg != '0)
                        bit_reg <= bit_reg - 6'd1;
                end
                FS_NEXT:
                begin
                    lane_reg <= lane_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath: load each lane in the load state, then one bit per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == FS_LOAD)
        begin
            div_reg <= sqrt_reg ? count - 21'd1 : count;
            rem_reg <= '0;
            quo_reg <= '0;
            if (sqrt_reg)
            begin
                num_reg <= devs[lane_reg*55 +: 55];
                neg_reg <= 1'b0;
            end
            else
            begin
                num_reg <= 55'(mag);
                neg_reg <= cur_sum[36];
            end
        end
        else if (state_reg == FS_DIV)
        begin
            num_reg <= {num_reg[53:0], 1'b0};
            if (rem_sh >= 56'(div_reg))
            begin
                rem_reg <= rem_sh - 56'(div_reg);
                quo_reg <= {quo_reg[53:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[53:0], 1'b0};
            end
            if (bit_reg == '0)
            begin
                rad_reg  <= {1'b0, quo_reg[53:0], rem_sh >= 56'(div_reg)};
                root_reg <= '0;
                srem_reg <= '0;
            end
        end
        else if (state_reg == FS_SQRT)
        begin
            rad_reg <= {rad_reg[53:0], 2'b00};
            if (srem_sh >= trial)
            begin
                srem_reg <= srem_sh - trial;
                root_reg <= {root_reg[26:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[26:0], 1'b0};
            end
        end
    end

    assign rem_nz    = rem_reg != '0;
    assign qfin      = quo_reg;
    assign mean_full = neg_reg ? -38'(qfin) - (rem_nz ? 38'sd1 : 38'sd0) : 38'(qfin);

    assign busy      = state_reg != FS_IDLE;
    assign mean_we   = (state_reg == FS_NEXT && !sqrt_reg) ? 4'(1) << lane_reg : '0;
    assign sigma_we  = (state_reg == FS_NEXT && sqrt_reg) ? 4'(1) << lane_reg : '0;
    assign mean_val  = (count == '0) ? '0 : mean_full[15:0];
    assign sigma_val = (count <= 21'd1) ? '0 : root_reg[SIGMA_W-1:0];
endmodule

[sv/n_sigma_row_selector.sv]
// ----------------------------------------------------------------------------
// n_sigma_row_selector: streaming n-sigma outlier row selector
// Output: one result per row, registered.
// Throughput: 1 row per cycle unless the output stalls or the shared pass-end
// unit is busy after the last row of pass 0 (divider) or pass 1 (divider + root).
// Reset: asynchronous, active low; clears all sums, means, sigmas and counts,
// registers to nsigma 1.0, include mode, all columns enabled.
// ----------------------------------------------------------------------------
module n_sigma_row_selector (
    input  logic      clk,
    input  logic      rst_n,
    nsr_in_if.sink    in_ch,
    nsr_out_if.source out_ch,
    input  logic      cfg_we,
    input  logic [nsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nsr_pkg::CFG_W-1:0]     cfg_data
);
    import nsr_pkg::*;

    logic [15:0]  nsigma_reg;
    logic         exclude_reg;
    logic [3:0]   enable_reg;
    logic [1:0]   pass_reg;
    logic [19:0]  rip_reg;      // rows in this pass, held at the last index
    logic         sat_reg;      // MAX_ROWS reached
    logic [20:0]  count_reg;
    logic         ovalid_reg;
    logic         keep_reg;
    logic [19:0]  rownum_reg;
    logic [1:0]   status_reg;
    logic         done_reg;

    logic         acc;
    logic         in_order;
    logic         busy;
    logic         fin_start;
    logic [3:0]   mean_we;
    logic [3:0]   sigma_we;
    logic [15:0]  mean_val;
    logic [SIGMA_W-1:0] sigma_val;
    logic [4*37-1:0] sums;
    logic [4*55-1:0] devs;
    lane_cut_t    cuts [COLUMNS];
    logic [15:0]  samples [COLUMNS];
    logic         all_ok;

    // the next row is taken only while the output register is empty or being read
    assign in_ch.ready = !busy && (!ovalid_reg || out_ch.ready);
    assign acc         = in_ch.valid && in_ch.ready;
    assign in_order    = in_ch.req_type == pass_reg;
    assign fin_start   = acc && in_order && in_ch.last_in_pass
                         && (pass_reg == PASS_MEAN || pass_reg == PASS_DEV);

    assign samples[0] = in_ch.sample_a;
    assign samples[1] = in_ch.sample_b;
    assign samples[2] = in_ch.sample_c;
    assign samples[3] = in_ch.sample_d;

    genvar g;
    generate
        for (g = 0; g < COLUMNS; g++)
        begin : g_lane
            nsr_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .sample   (samples[g]),
                .acc_sum  (acc && in_order && pass_reg == PASS_MEAN && !sat_reg),
                .acc_dev  (acc && in_order && pass_reg == PASS_DEV && !sat_reg),
                .clr_sum  (acc && in_order && pass_reg == PASS_CLASSIFY && in_ch.last_in_pass),
                .clr_dev  (mean_we[g]),
                .set_mean (mean_we[g]),
                .mean_val (mean_val),
                .set_sigma(sigma_we[g]),
                .sigma_val(sigma_val),
                .nsigma   (nsigma_reg),
                .enabled  (enable_reg[g]),
                .sum      (sums[g*37 +: 37]),
                .dev      (devs[g*55 +: 55]),
                .cut      (cuts[g])
            );
        end
    endgenerate

    // merge: every enabled lane must agree with the mode
    always_comb
    begin
        all_ok = 1'b1;
        for (int i = 0; i < COLUMNS; i++)
            if (cuts[i].enabled && (exclude_reg ? cuts[i].in_bound : !cuts[i].in_bound))
                all_ok = 1'b0;
    end

    nsr_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fin_start),
        .is_sqrt  (pass_reg == PASS_DEV),
        .count    (count_reg),
        .sums     (sums),
        .devs     (devs),
        .busy     (busy),
        .mean_we  (mean_we),
        .mean_val (mean_val),
        .sigma_we (sigma_we),
        .sigma_val(sigma_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsigma_reg  <= 16'd256;
            exclude_reg <= 1'b0;
            enable_reg  <= 4'hF;
            pass_reg    <= PASS_MEAN;
            rip_reg     <= '0;
            sat_reg     <= 1'b0;
            count_reg   <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NSIGMA:  nsigma_reg  <= cfg_data;
                    CFG_EXCLUDE: exclude_reg <= cfg_data[0];
                    CFG_ENABLE:  enable_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (out_ch.ready)
                ovalid_reg <= 1'b0;
            if (acc)
            begin
                ovalid_reg <= 1'b1;
                if (in_order)
                begin
                    if (in_ch.last_in_pass)
                    begin
                        rip_reg  <= '0;
                        sat_reg  <= 1'b0;
                        pass_reg <= (pass_reg == PASS_CLASSIFY) ? PASS_MEAN : pass_reg + 2'd1;
                    end
                    else if (!sat_reg)
                    begin
                        // the index sticks at its top value once the limit is hit
                        if (rip_reg == 20'(MAX_ROWS - 1))
                            sat_reg <= 1'b1;
                        else
                            rip_reg <= rip_reg + 20'd1;
                    end
                    if (pass_reg == PASS_MEAN && !sat_reg)
                        count_reg <= count_reg + 21'd1;
                    if (pass_reg == PASS_CLASSIFY && in_ch.last_in_pass)
                        count_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            keep_reg   <= in_order && pass_reg == PASS_CLASSIFY && all_ok;
            rownum_reg <= rip_reg;
            status_reg <= !in_order ? ST_ORDER : (sat_reg ? ST_SAT : ST_OK);
            done_reg   <= in_order && in_ch.last_in_pass;
        end
    end

    assign out_ch.valid      = ovalid_reg;
    assign out_ch.keep_row   = keep_reg;
    assign out_ch.row_number = rownum_reg;
    assign out_ch.status     = status_reg;
    assign out_ch.pass_done  = done_reg;

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ch.ready) else $error("row taken during pass-end work");
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == ST_ORDER) |-> !out_ch.pass_done && !out_ch.keep_row)
        else $error("ignored row marked");
    a_fin_start: assert property (@(posedge clk) disable iff (!rst_n)
        fin_start |=> busy) else $error("pass-end unit did not start");
endmodule
